@@ hw/rtl/assert_macros.svh @@
// ============================================================================
// Assertion macros
// Shared wrappers for the concurrent checks in the RTL.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked check with an active-low reset that disables it.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on the block clock and reset.
`define ASSERT_CHK(lbl, prop, msg) \
    `ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`endif

@@ hw/rtl/rdf_pkg.sv @@
// ============================================================================
// rdf_pkg
// Types, codes and helpers of the delta-coded frame decoder.
// ============================================================================
package rdf_pkg;

    localparam int unsigned POS_W   = 17;
    localparam int unsigned LEN_W   = 12;
    localparam int unsigned BYTE_W  = 8;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    localparam logic [LEN_W-1:0]  STRIDE_RST = 12'd320;
    localparam logic [POS_W-1:0]  FRAME_RST  = 17'd64000;
    localparam logic [BYTE_W-1:0] FILL_RST   = 8'hff;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_LINE_STRIDE = 2'd0;
    localparam logic [1:0] REG_FRAME_BYTES = 2'd1;
    localparam logic [1:0] REG_FILL_VALUE  = 2'd2;

    // Opcodes and opcode classes (high nibble).
    localparam logic [7:0] OPC_END       = 8'h00;
    localparam logic [7:0] OPC_NEXT_LINE = 8'h10;
    localparam logic [3:0] HI_SKIP4      = 4'h2;
    localparam logic [3:0] HI_SKIP12     = 4'h3;
    localparam logic [3:0] HI_FILL4      = 4'h4;
    localparam logic [3:0] HI_FILL12     = 4'h5;
    localparam logic [3:0] HI_LIT4       = 4'h6;
    localparam logic [3:0] HI_LIT12      = 4'h7;
    localparam logic [3:0] HI_REP4       = 4'h8;
    localparam logic [3:0] HI_REP12      = 4'h9;

    typedef enum logic [1:0] {
        PH_OPCODE = 2'd0,
        PH_COUNT  = 2'd1,
        PH_DATA   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        OC_SKIP    = 2'd0,
        OC_FILL    = 2'd1,
        OC_LITERAL = 2'd2,
        OC_REPEAT  = 2'd3
    } t_op_class;

    typedef enum logic [1:0] {
        KIND_RUN     = 2'd0,
        KIND_END     = 2'd1,
        KIND_UNKNOWN = 2'd2
    } t_kind;

    // Position add that sticks at the largest address.
    function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] a,
                                                 input logic [POS_W-1:0] b);
        logic [POS_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[POS_W] ? POS_MAX : s[POS_W-1:0];
    endfunction

endpackage

@@ hw/rtl/rle_delta_frame_decoder_unit.sv @@
// ============================================================================
// rle_delta_frame_decoder_unit
// Decodes the byte stream of one delta-coded frame into write descriptors.
// ============================================================================
// The decoder takes one coded byte per transfer and produces at most one write
// descriptor per byte, so it sustains one byte per clock cycle while the
// output is not stalled: the byte is captured in an input register, then the
// opcode decode, the position adders and the out-of-frame compare run
// combinationally and land in the result register together with the updated
// line base, column and parser state. Either register advances whenever the
// stage after it is free or is being emptied in the same cycle, so a new byte
// is taken while a finished descriptor still waits on the output. Skip and
// next-line codes produce no descriptor; a fill or repeat run and each literal
// data byte produce one descriptor with start address, length and value; the
// end code produces a frame-done descriptor and moves back to the frame
// origin; an unknown code produces a report at the current address and is
// otherwise ignored. Line base, column and run addresses saturate at the top
// of the 17-bit address space. The registers line_stride (0x0), frame_bytes
// (0x4) and fill_value (0x8) sit on an APB-style port that always completes
// in its access cycle and should be written only while the decoder is idle.
module rle_delta_frame_decoder_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Coded byte input
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [rdf_pkg::BYTE_W-1:0]  i_code_byte,
    // Descriptor output
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [1:0]                  o_kind,
    output logic [rdf_pkg::POS_W-1:0]   o_run_address,
    output logic [rdf_pkg::LEN_W-1:0]   o_run_length,
    output logic [rdf_pkg::BYTE_W-1:0]  o_run_value,
    output logic                        o_out_of_frame,
    // Configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [3:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import rdf_pkg::*;

    `include "assert_macros.svh"

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [LEN_W-1:0]  r_line_stride;
    logic [POS_W-1:0]  r_frame_bytes;
    logic [BYTE_W-1:0] r_fill_value;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_stride <= STRIDE_RST;
            r_frame_bytes <= FRAME_RST;
            r_fill_value  <= FILL_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_LINE_STRIDE: r_line_stride <= pwdata[LEN_W-1:0];
                REG_FRAME_BYTES: r_frame_bytes <= pwdata[POS_W-1:0];
                REG_FILL_VALUE:  r_fill_value  <= pwdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_LINE_STRIDE: prdata = {{(32-LEN_W){1'b0}}, r_line_stride};
            REG_FRAME_BYTES: prdata = {{(32-POS_W){1'b0}}, r_frame_bytes};
            REG_FILL_VALUE:  prdata = {{(32-BYTE_W){1'b0}}, r_fill_value};
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control: input register, then result register.
    // ------------------------------------------------------------------
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    logic              advance;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign o_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_code_byte;
        end
    end

    // ------------------------------------------------------------------
    // Parser state
    // ------------------------------------------------------------------
    t_phase            r_phase,      n_phase;
    t_op_class         r_op_class,   n_op_class;
    logic [3:0]        r_count_high, n_count_high;
    logic [LEN_W-1:0]  r_remaining,  n_remaining;
    logic [POS_W-1:0]  r_line_base,  n_line_base;
    logic [POS_W-1:0]  r_column,     n_column;

    // Result of the decode for the byte in the input register.
    logic              emit;
    t_kind             res_kind;
    logic [POS_W-1:0]  res_addr;
    logic [LEN_W-1:0]  res_len;
    logic [BYTE_W-1:0] res_val;
    logic              res_oof;

    logic [3:0]        hi, lo;
    logic [LEN_W-1:0]  cnt12;
    logic [POS_W-1:0]  cur_addr;
    logic              run_req;
    logic [LEN_W-1:0]  run_len;
    logic [BYTE_W-1:0] run_val;
    logic              col_adv;
    logic [LEN_W-1:0]  col_add;
    logic              unknown;
    logic [LEN_W-1:0]  rem_dec;
    logic [POS_W:0]    run_end;

    assign hi       = r_in_byte[7:4];
    assign lo       = r_in_byte[3:0];
    assign cnt12    = {r_count_high, r_in_byte};
    assign cur_addr = sat_add(r_line_base, r_column);
    assign rem_dec  = (r_remaining != '0) ? r_remaining - 1'b1 : '0;

    always_comb begin
        n_phase      = r_phase;
        n_op_class   = r_op_class;
        n_count_high = r_count_high;
        n_remaining  = r_remaining;
        n_line_base  = r_line_base;
        run_req      = 1'b0;
        run_len      = '0;
        run_val      = '0;
        col_adv      = 1'b0;
        col_add      = '0;
        unknown      = 1'b0;
        emit         = 1'b0;
        res_kind     = KIND_RUN;

        case (r_phase)
            PH_COUNT: begin
                // Low byte of a 12-bit count.
                n_phase = PH_OPCODE;
                case (r_op_class)
                    OC_SKIP: begin
                        col_adv = 1'b1;
                        col_add = cnt12;
                    end
                    OC_FILL: begin
                        run_req = 1'b1;
                        run_len = cnt12;
                        run_val = r_fill_value;
                    end
                    OC_LITERAL: begin
                        if (cnt12 != '0) begin
                            n_remaining = cnt12;
                            n_phase     = PH_DATA;
                        end
                    end
                    default: begin
                        // A zero repeat count still consumes its value byte.
                        n_remaining = cnt12;
                        n_phase     = PH_DATA;
                    end
                endcase
            end
            PH_DATA: begin
                if (r_op_class == OC_LITERAL) begin
                    n_remaining = rem_dec;
                    if (rem_dec == '0) begin
                        n_phase = PH_OPCODE;
                    end
                    run_req = 1'b1;
                    run_len = LEN_W'(1);
                    run_val = r_in_byte;
                end else begin
                    n_phase     = PH_OPCODE;
                    n_remaining = '0;
                    run_req     = 1'b1;
                    run_len     = r_remaining;
                    run_val     = r_in_byte;
                end
            end
            default: begin
                n_phase = PH_OPCODE;
                if (r_in_byte == OPC_END) begin
                    emit     = 1'b1;
                    res_kind = KIND_END;
                end else if (r_in_byte == OPC_NEXT_LINE) begin
                    n_line_base = sat_add(r_line_base, {{(POS_W-LEN_W){1'b0}}, r_line_stride});
                end else begin
                    case (hi)
                        HI_SKIP4: begin
                            col_adv = 1'b1;
                            col_add = {{(LEN_W-4){1'b0}}, lo};
                        end
                        HI_SKIP12, HI_FILL12, HI_LIT12, HI_REP12: begin
                            n_op_class   = t_op_class'(2'((hi - 4'd3) >> 1));
                            n_count_high = lo;
                            n_phase      = PH_COUNT;
                        end
                        HI_FILL4: begin
                            if (lo == 4'd0) begin
                                unknown = 1'b1;
                            end else begin
                                run_req = 1'b1;
                                run_len = {{(LEN_W-4){1'b0}}, lo};
                                run_val = r_fill_value;
                            end
                        end
                        HI_LIT4, HI_REP4: begin
                            if (lo == 4'd0) begin
                                unknown = 1'b1;
                            end else begin
                                n_op_class  = (hi == HI_LIT4) ? OC_LITERAL : OC_REPEAT;
                                n_remaining = {{(LEN_W-4){1'b0}}, lo};
                                n_phase     = PH_DATA;
                            end
                        end
                        default: unknown = 1'b1;
                    endcase
                end
            end
        endcase

        // A run of zero length writes nothing and leaves the column alone.
        if (run_req && run_len != '0) begin
            emit     = 1'b1;
            res_kind = KIND_RUN;
            col_adv  = 1'b1;
            col_add  = run_len;
        end
        if (unknown) begin
            emit     = 1'b1;
            res_kind = KIND_UNKNOWN;
        end

        // Column update; the end and next-line codes return to column zero.
        if (r_phase != PH_COUNT && r_phase != PH_DATA &&
            (r_in_byte == OPC_END || r_in_byte == OPC_NEXT_LINE)) begin
            n_column = '0;
        end else if (col_adv) begin
            n_column = sat_add(r_column, {{(POS_W-LEN_W){1'b0}}, col_add});
        end else begin
            n_column = r_column;
        end
        if (res_kind == KIND_END && emit) begin
            n_line_base = '0;
        end
    end

    // Descriptor fields. Non-write kinds carry zero length, value and flag.
    assign run_end = {1'b0, cur_addr} + {{(POS_W+1-LEN_W){1'b0}}, run_len};

    always_comb begin
        case (res_kind)
            KIND_RUN: begin
                res_addr = cur_addr;
                res_len  = run_len;
                res_val  = run_val;
                res_oof  = run_end > {1'b0, r_frame_bytes};
            end
            KIND_UNKNOWN: begin
                res_addr = cur_addr;
                res_len  = '0;
                res_val  = '0;
                res_oof  = 1'b0;
            end
            default: begin
                res_addr = '0;
                res_len  = '0;
                res_val  = '0;
                res_oof  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_OPCODE;
            r_op_class   <= OC_SKIP;
            r_count_high <= '0;
            r_remaining  <= '0;
            r_line_base  <= '0;
            r_column     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (advance) begin
                r_phase      <= n_phase;
                r_op_class   <= n_op_class;
                r_count_high <= n_count_high;
                r_remaining  <= n_remaining;
                r_line_base  <= n_line_base;
                r_column     <= n_column;
            end
            if (advance) begin
                r_out_valid <= emit;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    logic [1:0]        r_kind;
    logic [POS_W-1:0]  r_run_address;
    logic [LEN_W-1:0]  r_run_length;
    logic [BYTE_W-1:0] r_run_value;
    logic              r_out_of_frame;

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_kind         <= res_kind;
            r_run_address  <= res_addr;
            r_run_length   <= res_len;
            r_run_value    <= res_val;
            r_out_of_frame <= res_oof;
        end
    end

    assign o_kind         = r_kind;
    assign o_run_address  = r_run_address;
    assign o_run_length   = r_run_length;
    assign o_run_value    = r_run_value;
    assign o_out_of_frame = r_out_of_frame;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `ASSERT_CHK(a_run_nonzero, (o_valid && o_kind == KIND_RUN) |-> (o_run_length != '0), "write descriptor with zero length")
    `ASSERT_CHK(a_report_clean, (o_valid && o_kind != KIND_RUN) |-> (o_run_length == '0 && o_run_value == '0 && !o_out_of_frame), "non-write descriptor carries run data")
    `ASSERT_CHK(a_end_at_origin, (o_valid && o_kind == KIND_END) |-> (o_run_address == '0), "frame-done descriptor away from origin")
    `ASSERT_CHK(a_in_hold, (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_byte)), "input register lost a stalled byte")

endmodule

@@ test/rle_delta_frame_decoder_unit_tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// rle_delta_frame_decoder_unit_tb
// Self-checking bench for the delta-coded frame decoder. A short directed
// stream hits the opcode extremes, zero-length runs, unknown codes and the
// end code. Random opcode sequences then run under several register
// settings and idle patterns. Every descriptor is compared field by field
// with the bench's own decoder model or a hand-written descriptor.
// ============================================================================
module rle_delta_frame_decoder_unit_tb;
    import rdf_pkg::*;

    // Descriptor as the bench predicts it, one field per output port.
    typedef struct packed {
        t_kind              kind;
        logic [POS_W-1:0]   addr;
        logic [LEN_W-1:0]   len;
        logic [BYTE_W-1:0]  value;
        logic               oof;
    } t_run_desc;

    // How a row of the directed stream is checked: by the model, by a
    // hand-written descriptor, or by expecting nothing at all.
    typedef enum logic [1:0] {
        CHK_PRED,
        CHK_NONE,
        CHK_WANT
    } t_row_check;

    typedef struct {
        logic [7:0]  code;
        t_row_check  chk;
        t_run_desc   want;
    } t_code_row;

    // ------------------------------------------------------------------------
    // Block ports. Every input has a known value from time zero.
    // ------------------------------------------------------------------------
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [BYTE_W-1:0]  i_code_byte = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [1:0]         o_kind;
    logic [POS_W-1:0]   o_run_address;
    logic [LEN_W-1:0]   o_run_length;
    logic [BYTE_W-1:0]  o_run_value;
    logic               o_out_of_frame;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [3:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    rle_delta_frame_decoder_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_code_byte    (i_code_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_kind         (o_kind),
        .o_run_address  (o_run_address),
        .o_run_length   (o_run_length),
        .o_run_value    (o_run_value),
        .o_out_of_frame (o_out_of_frame),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // 20 ns clock period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Bench state: register copies, decoder model state and the queue of
    // descriptors that the block still owes.
    // ------------------------------------------------------------------------
    logic [LEN_W-1:0]   stride_reg = STRIDE_RST;
    logic [POS_W-1:0]   frame_reg  = FRAME_RST;
    logic [BYTE_W-1:0]  fill_reg   = FILL_RST;

    t_phase             dec_phase  = PH_OPCODE;
    t_op_class          dec_class  = OC_SKIP;
    logic [3:0]         dec_cnt_hi = '0;
    logic [LEN_W-1:0]   dec_left   = '0;
    logic [POS_W-1:0]   line_base  = '0;
    logic [POS_W-1:0]   column     = '0;

    t_run_desc          pending_runs[$];
    int                 fail_count = 0;
    int                 codes_sent = 0;
    int                 tx_idle_pct = 0;
    int                 rx_stall_pct = 0;

    // Directed stream, run straight after reset with the reset register
    // values. Hand-written descriptors only where the answer is obvious.
    t_code_row dir_rows [32] = '{
        '{OPC_END,            CHK_WANT, '{KIND_END, 17'd0, 12'd0, 8'd0, 1'b0}},
        '{8'h01,              CHK_WANT, '{KIND_UNKNOWN, 17'd0, 12'd0, 8'd0, 1'b0}},
        '{{HI_SKIP4, 4'hF},   CHK_NONE, '0},
        '{{HI_FILL4, 4'hF},   CHK_WANT, '{KIND_RUN, 17'd15, 12'd15, 8'hFF, 1'b0}},
        '{{HI_SKIP12, 4'hF},  CHK_NONE, '0},
        '{8'hFF,              CHK_NONE, '0},
        '{{HI_FILL12, 4'hF},  CHK_NONE, '0},
        '{8'hFF,              CHK_WANT, '{KIND_RUN, 17'd4125, 12'd4095, 8'hFF, 1'b0}},
        '{OPC_NEXT_LINE,      CHK_NONE, '0},
        '{{HI_LIT4, 4'h1},    CHK_NONE, '0},
        '{8'hA5,              CHK_PRED, '0},
        '{{HI_REP4, 4'h2},    CHK_NONE, '0},
        '{8'h00,              CHK_PRED, '0},
        '{{HI_FILL12, 4'h0},  CHK_NONE, '0},
        '{8'h00,              CHK_NONE, '0},
        '{{HI_LIT12, 4'h0},   CHK_NONE, '0},
        '{8'h00,              CHK_NONE, '0},
        '{{HI_REP12, 4'h0},   CHK_NONE, '0},
        '{8'h00,              CHK_NONE, '0},
        '{8'h7E,              CHK_NONE, '0},
        '{{HI_LIT12, 4'h0},   CHK_NONE, '0},
        '{8'h02,              CHK_NONE, '0},
        '{8'h11,              CHK_PRED, '0},
        '{8'hEE,              CHK_PRED, '0},
        '{{HI_REP12, 4'h1},   CHK_NONE, '0},
        '{8'h00,              CHK_NONE, '0},
        '{8'h55,              CHK_PRED, '0},
        '{{HI_FILL4, 4'h0},   CHK_PRED, '0},
        '{{HI_LIT4, 4'h0},    CHK_PRED, '0},
        '{{HI_REP4, 4'h0},    CHK_PRED, '0},
        '{8'hFF,              CHK_PRED, '0},
        '{OPC_END,            CHK_WANT, '{KIND_END, 17'd0, 12'd0, 8'd0, 1'b0}}
    };

    // ------------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------------

    // Position add that sticks at the top of the address space.
    function automatic logic [POS_W-1:0] pos_add(input int unsigned a, input int unsigned b);
        return (a + b > POS_MAX) ? POS_MAX : POS_W'(a + b);
    endfunction

    // A run starts at the current position and moves the column past it.
    // Zero-length runs leave everything alone and produce nothing.
    task automatic put_run(input logic [LEN_W-1:0] len, input logic [BYTE_W-1:0] value,
                           output bit got, output t_run_desc d);
        int unsigned start;
        got = 1'b0;
        d = '0;
        if (len != 0) begin
            start = pos_add(line_base, column);
            column = pos_add(column, len);
            got = 1'b1;
            d = '{KIND_RUN, POS_W'(start), len, value, (start + len > frame_reg)};
        end
    endtask

    // Advances the model by one coded byte and returns the descriptor, if any.
    task automatic decode_byte(input logic [7:0] b, output bit got, output t_run_desc d);
        logic [3:0]        hi;
        logic [3:0]        lo;
        logic [LEN_W-1:0]  cnt;
        bit                bad;
        hi = b[7:4];
        lo = b[3:0];
        bad = 1'b0;
        got = 1'b0;
        d = '0;
        case (dec_phase)
            PH_COUNT: begin
                cnt = {dec_cnt_hi, b};
                dec_phase = PH_OPCODE;
                case (dec_class)
                    OC_SKIP: column = pos_add(column, cnt);
                    OC_FILL: put_run(cnt, fill_reg, got, d);
                    OC_LITERAL: begin
                        // A zero-length literal goes straight back to opcodes.
                        if (cnt != 0) begin
                            dec_left = cnt;
                            dec_phase = PH_DATA;
                        end
                    end
                    default: begin
                        // A repeat always takes its value byte, even at zero.
                        dec_left = cnt;
                        dec_phase = PH_DATA;
                    end
                endcase
            end
            PH_DATA: begin
                if (dec_class == OC_LITERAL) begin
                    if (dec_left != 0) dec_left = dec_left - 1'b1;
                    if (dec_left == 0) dec_phase = PH_OPCODE;
                    put_run(12'd1, b, got, d);
                end else begin
                    cnt = dec_left;
                    dec_left = '0;
                    dec_phase = PH_OPCODE;
                    put_run(cnt, b, got, d);
                end
            end
            default: begin
                dec_phase = PH_OPCODE;
                if (b == OPC_END) begin
                    line_base = '0;
                    column = '0;
                    got = 1'b1;
                    d.kind = KIND_END;
                end else if (b == OPC_NEXT_LINE) begin
                    line_base = pos_add(line_base, stride_reg);
                    column = '0;
                end else begin
                    case (hi)
                        HI_SKIP4: column = pos_add(column, lo);
                        HI_SKIP12, HI_FILL12, HI_LIT12, HI_REP12: begin
                            // Odd high nibbles 3, 5, 7, 9 map onto the four classes.
                            dec_class = t_op_class'(2'((hi - 4'd3) >> 1));
                            dec_cnt_hi = lo;
                            dec_phase = PH_COUNT;
                        end
                        HI_FILL4: begin
                            if (lo != 0) put_run(LEN_W'(lo), fill_reg, got, d);
                            else bad = 1'b1;
                        end
                        HI_LIT4, HI_REP4: begin
                            if (lo != 0) begin
                                dec_class = (hi == HI_LIT4) ? OC_LITERAL : OC_REPEAT;
                                dec_left = LEN_W'(lo);
                                dec_phase = PH_DATA;
                            end else begin
                                bad = 1'b1;
                            end
                        end
                        default: bad = 1'b1;
                    endcase
                end
            end
        endcase
        // Unknown codes are reported at the current address and skipped.
        if (bad) begin
            got = 1'b1;
            d = '0;
            d.kind = KIND_UNKNOWN;
            d.addr = pos_add(line_base, column);
        end
    endtask

    // ------------------------------------------------------------------------
    // Code byte sender. Every task below is entered just after a rising edge
    // and returns just after one, so each signal gets one update per edge.
    // ------------------------------------------------------------------------
    task automatic send_code(input logic [7:0] b, input t_row_check chk = CHK_PRED,
                             input t_run_desc want = '0);
        bit         got;
        t_run_desc  d;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_code_byte <= b;
        // o_ready read here is the value the edge just sampled.
        do @(posedge i_clk); while (!o_ready);
        codes_sent++;
        decode_byte(b, got, d);
        case (chk)
            CHK_PRED: if (got) pending_runs.push_back(d);
            CHK_WANT: pending_runs.push_back(want);
            default: ;
        endcase
    endtask

    // One random opcode with its operands. Most picks are well-formed; the
    // last slice is a raw byte, which may be unknown or may start an opcode
    // whose operands are then taken from whatever follows.
    task automatic send_op();
        int          pick;
        logic [3:0]  lo;
        pick = $urandom_range(99);
        lo = 4'($urandom_range(15, 1));
        if (pick < 4) begin
            send_code(OPC_END);
        end else if (pick < 12) begin
            send_code(OPC_NEXT_LINE);
        end else if (pick < 20) begin
            send_code({HI_SKIP4, 4'($urandom_range(15))});
        end else if (pick < 28) begin
            send_code({HI_SKIP12, 4'($urandom_range(15))});
            send_code(8'($urandom_range(255)));
        end else if (pick < 38) begin
            send_code({HI_FILL4, lo});
        end else if (pick < 46) begin
            send_code({HI_FILL12, 4'($urandom_range(15))});
            send_code(8'($urandom_range(255)));
        end else if (pick < 58) begin
            send_code({HI_LIT4, lo});
            repeat (lo) send_code(8'($urandom_range(255)));
        end else if (pick < 64) begin
            // Long literals would swamp the stream, so keep their counts short.
            send_code({HI_LIT12, 4'h0});
            lo = 4'($urandom_range(15));
            send_code({4'h0, lo});
            repeat (lo) send_code(8'($urandom_range(255)));
        end else if (pick < 76) begin
            send_code({HI_REP4, lo});
            send_code(8'($urandom_range(255)));
        end else if (pick < 88) begin
            send_code({HI_REP12, 4'($urandom_range(15))});
            send_code(8'($urandom_range(255)));
            send_code(8'($urandom_range(255)));
        end else begin
            send_code(8'($urandom_range(255)));
        end
    endtask

    // Drops valid, waits for every owed descriptor, then lets the pipeline
    // settle so that a trailing operand byte has surely been consumed.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_runs.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------------
    function automatic logic [31:0] reg_mask(input logic [1:0] idx);
        case (idx)
            REG_LINE_STRIDE: return (32'd1 << LEN_W) - 1;
            REG_FRAME_BYTES: return (32'd1 << POS_W) - 1;
            default:         return (32'd1 << BYTE_W) - 1;
        endcase
    endfunction

    // Setup phase, access phase, then an idle phase so that back-to-back
    // calls never lower and raise psel at the same edge.
    task automatic apb_xfer(input logic [1:0] idx, input bit wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_reg(input logic [1:0] idx);
        logic [31:0] rdata;
        logic [31:0] want;
        case (idx)
            REG_LINE_STRIDE: want = 32'(stride_reg);
            REG_FRAME_BYTES: want = 32'(frame_reg);
            default:         want = 32'(fill_reg);
        endcase
        apb_xfer(idx, 1'b0, '0, rdata);
        if (rdata !== want) begin
            $display("%0t: register %0d readback mismatch: expected 0x%0h, actual 0x%0h",
                     $time, idx, want, rdata);
            fail_count++;
        end
    endtask

    // Writes a register with random junk above its width, which the block
    // must drop, then reads it back.
    task automatic program_reg(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] wdata;
        logic [31:0] unused;
        wdata = ($urandom & ~reg_mask(idx)) | (value & reg_mask(idx));
        apb_xfer(idx, 1'b1, wdata, unused);
        case (idx)
            REG_LINE_STRIDE: stride_reg = wdata[LEN_W-1:0];
            REG_FRAME_BYTES: frame_reg = wdata[POS_W-1:0];
            default:         fill_reg = wdata[BYTE_W-1:0];
        endcase
        check_reg(idx);
    endtask

    // ------------------------------------------------------------------------
    // Descriptor receiver: random stalls, and the check of every transfer
    // against the oldest owed descriptor.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_run_desc want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_runs.size() == 0) begin
                $display("%0t: unexpected descriptor: expected none, actual kind %0d addr 0x%0h",
                         $time, o_kind, o_run_address);
                fail_count++;
            end else begin
                want = pending_runs.pop_front();
                check_field("kind", want.kind, o_kind);
                check_field("run_address", want.addr, o_run_address);
                check_field("run_length", want.len, o_run_length);
                check_field("run_value", want.value, o_run_value);
                check_field("out_of_frame", want.oof, o_out_of_frame);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int phase_end;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values must be visible on the port.
        check_reg(REG_LINE_STRIDE);
        check_reg(REG_FRAME_BYTES);
        check_reg(REG_FILL_VALUE);

        foreach (dir_rows[r]) send_code(dir_rows[r].code, dir_rows[r].chk, dir_rows[r].want);

        // Random phases. Each one but the first changes the registers while the
        // decoder is idle; every phase then runs under one of four idle patterns.
        for (int ph = 0; ph < 6; ph++) begin
            wait_drained();
            case (ph)
                1: begin
                    // Lowest values: almost every run crosses the frame end.
                    program_reg(REG_LINE_STRIDE, 32'd1);
                    program_reg(REG_FRAME_BYTES, 32'd1);
                    program_reg(REG_FILL_VALUE, 32'd0);
                end
                2: begin
                    program_reg(REG_LINE_STRIDE, 32'd4095);
                    program_reg(REG_FRAME_BYTES, 32'd131071);
                    program_reg(REG_FILL_VALUE, 32'd255);
                end
                3: begin
                    program_reg(REG_LINE_STRIDE, $urandom_range(4095, 1));
                    program_reg(REG_FRAME_BYTES, $urandom_range(131071, 1));
                    program_reg(REG_FILL_VALUE, $urandom_range(255));
                end
                4: begin
                    // A small frame so that both flag values show up often.
                    program_reg(REG_LINE_STRIDE, $urandom_range(64, 1));
                    program_reg(REG_FRAME_BYTES, $urandom_range(2000, 1));
                    program_reg(REG_FILL_VALUE, $urandom_range(255));
                end
                5: begin
                    program_reg(REG_LINE_STRIDE, 32'(STRIDE_RST));
                    program_reg(REG_FRAME_BYTES, 32'(FRAME_RST));
                    program_reg(REG_FILL_VALUE, $urandom_range(255));
                end
                default: ;
            endcase
            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 71; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 71; end
                default: begin tx_idle_pct = 13; rx_stall_pct = 13; end
            endcase
            if (ph == 2) begin
                // Drive the column, then the line base, into saturation and
                // place runs at the very top of the address space.
                repeat (33) begin
                    send_code({HI_SKIP12, 4'hF});
                    send_code(8'hFF);
                end
                send_code({HI_FILL4, 4'hF});
                repeat (34) send_code(OPC_NEXT_LINE);
                send_code({HI_FILL12, 4'hF});
                send_code(8'hFF);
                send_code({HI_REP4, 4'h3});
                send_code(8'h5A);
                send_code(8'hC3);
                send_code(OPC_END);
            end
            phase_end = codes_sent + 210;
            while (codes_sent < phase_end) send_op();
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("rle_delta_frame_decoder_unit_tb: PASS");
        end else begin
            $display("rle_delta_frame_decoder_unit_tb: FAIL");
        end
        $finish;
    end

    // Hang guard, far above the slowest legal run of about 1400 coded bytes.
    initial begin
        #10_000_000;
        $display("rle_delta_frame_decoder_unit_tb: FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/rdf_pkg.sv
hw/rtl/rle_delta_frame_decoder_unit.sv
test/rle_delta_frame_decoder_unit_tb.sv
